// ===== design/nvme_queue_pair_tracker_defines.svh =====
// assertion macros used by the checker file
`ifndef NVME_QUEUE_PAIR_TRACKER_DEFINES_SVH
`define NVME_QUEUE_PAIR_TRACKER_DEFINES_SVH

// checked only while out of reset
`define NVMEQPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NVMEQPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/nvmeqpt_pkg.sv =====
// types, codes and pointer helpers for the queue pair tracker
package nvmeqpt_pkg;

    localparam int MAX_DEPTH = 256;
    localparam logic [16:0] LAST_LIMIT = 17'(MAX_DEPTH - 1);

    localparam logic MODE_SUBMIT   = 1'b0;
    localparam logic MODE_COMPLETE = 1'b1;

    localparam logic [1:0] OUT_SUBMITTED = 2'd0;
    localparam logic [1:0] OUT_FULL      = 2'd1;
    localparam logic [1:0] OUT_CONSUMED  = 2'd2;
    localparam logic [1:0] OUT_NOT_READY = 2'd3;

    localparam logic CFG_SQ_LAST = 1'b0;
    localparam logic CFG_CQ_LAST = 1'b1;

    localparam logic [7:0] SQ_LAST_RESET = 8'd63;
    localparam logic [7:0] CQ_LAST_RESET = 8'd255;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic        mode;
        logic [15:0] dw0_low;
        logic [15:0] status;
        logic [7:0]  rep_head;
        logic        failed;
    } item_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [7:0]  sq_slot;
        logic [31:0] cmd_dword0_out;
        logic [7:0]  sq_doorbell_value;
        logic [7:0]  cq_doorbell_value;
        logic [15:0] completion_status;
        logic        command_failed;
    } result_t;

    // wrap-compare increment, wrap point clamped to the last index of the queue depth
    function automatic logic [7:0] wrap_next(input logic [7:0] ptr, input logic [7:0] last);
        logic [16:0] lim;
        lim = ({9'd0, last} > LAST_LIMIT) ? LAST_LIMIT : {9'd0, last};
        if ({9'd0, ptr} >= lim)
            return 8'd0;
        return ptr + 8'd1;
    endfunction

endpackage

// ===== design/nvmeqpt_front.sv =====
// front end: takes input transfers, classifies them and queues them for the back end
module nvmeqpt_front
    import nvmeqpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_mode,
    input  logic [IN_DATA_W-1:0] in_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output item_t                q_item
);

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    item_t       incoming;
    logic        push;
    logic        pop;

    always_comb
    begin
        incoming.mode     = in_mode;
        incoming.dw0_low  = in_data[15:0];
        incoming.status   = in_data[47:32];
        incoming.rep_head = in_data[55:48];
        // error flag from status bits 8..1
        incoming.failed   = |in_data[40:33];
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= incoming;
    end

endmodule

// ===== design/nvmeqpt_back.sv =====
// back end: holds queue pointers and phase, executes items, drives the result register
module nvmeqpt_back
    import nvmeqpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_result
);

    logic [7:0] sq_last_reg;
    logic [7:0] cq_last_reg;
    logic [7:0] sq_tail_reg;
    logic [7:0] sq_tail_next;
    logic [7:0] sq_head_reg;
    logic [7:0] sq_head_next;
    logic [7:0] cq_head_reg;
    logic [7:0] cq_head_next;
    logic       cq_phase_reg;
    logic       cq_phase_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_next;
    logic [7:0] sq_step;
    logic [7:0] cq_step;
    logic       take;

    assign q_ready    = !out_valid_reg || out_ready;
    assign take       = q_valid && q_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign sq_step = wrap_next(sq_tail_reg, sq_last_reg);
    assign cq_step = wrap_next(cq_head_reg, cq_last_reg);

    always_comb
    begin
        sq_tail_next   = sq_tail_reg;
        sq_head_next   = sq_head_reg;
        cq_head_next   = cq_head_reg;
        cq_phase_next  = cq_phase_reg;
        result_next    = '0;
        out_valid_next = out_valid_reg && !out_ready;
        if (take)
        begin
            out_valid_next = 1'b1;
            unique case (q_item.mode)
                MODE_SUBMIT:
                begin
                    if (sq_step == sq_head_reg)
                        result_next.outcome = OUT_FULL;
                    else
                    begin
                        result_next.outcome           = OUT_SUBMITTED;
                        result_next.sq_slot           = sq_tail_reg;
                        // command identifier replaces bits 31..16
                        result_next.cmd_dword0_out    = {8'd0, sq_tail_reg, q_item.dw0_low};
                        result_next.sq_doorbell_value = sq_step;
                        sq_tail_next                  = sq_step;
                    end
                end
                MODE_COMPLETE:
                begin
                    if (q_item.status[0] != cq_phase_reg)
                        result_next.outcome = OUT_NOT_READY;
                    else
                    begin
                        result_next.outcome           = OUT_CONSUMED;
                        result_next.cq_doorbell_value = cq_step;
                        result_next.completion_status = q_item.status;
                        result_next.command_failed    = q_item.failed;
                        cq_head_next                  = cq_step;
                        sq_head_next                  = q_item.rep_head;
                        if (cq_step < cq_head_reg)
                            cq_phase_next = ~cq_phase_reg;
                    end
                end
                default:
                begin
                    result_next.outcome = OUT_NOT_READY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_last_reg   <= SQ_LAST_RESET;
            cq_last_reg   <= CQ_LAST_RESET;
            sq_tail_reg   <= 8'd0;
            sq_head_reg   <= 8'd0;
            cq_head_reg   <= 8'd0;
            cq_phase_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SQ_LAST: sq_last_reg <= cfg_data;
                    CFG_CQ_LAST: cq_last_reg <= cfg_data;
                    default:     sq_last_reg <= sq_last_reg;
                endcase
            end
            sq_tail_reg   <= sq_tail_next;
            sq_head_reg   <= sq_head_next;
            cq_head_reg   <= cq_head_next;
            cq_phase_reg  <= cq_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

endmodule

// ===== design/nvme_queue_pair_tracker.sv =====
// top level of the queue pair tracker
//
// s_axis carries one item per transfer: s_axis_tuser 0 submits the command dword 0
// in s_axis_tdata, 1 examines the completion slot whose status and reported
// submission head sit in s_axis_tdata. Every item gives exactly one result on
// m_axis, in order, its kind in m_axis_tuser (submitted, full, consumed, not ready).
// cfg_we writes sq_last_index (index 0) or cq_last_index (index 1) on the clock edge;
// write only while no item is in flight.
// From input transfer to m_axis_tvalid an item passes the two-entry input queue of the
// front end and then the result register of the back end.
// Throughput is one item per cycle while m_axis_tready is high; the wrap-compare pointer
// update in the back end is combinational.
// When m_axis_tready is low the result register holds, the queue fills, and
// s_axis_tready drops once both queue entries are taken.
// rst_n clears pointers to zero, the expected phase to one, the wrap points to
// 63 and 255, and empties the queue and result register.
module nvme_queue_pair_tracker
    import nvmeqpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cmd_dword0[31:0], cqe_status[47:32], cqe_sq_head[55:48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sq_slot[7:0], cmd_dword0_out[39:8], sq_doorbell_value[47:40],
    // cq_doorbell_value[55:48], completion_status[71:56], command_failed[72], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // outcome[1:0]
    output logic [1:0]            m_axis_tuser,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data
);

    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t res;

    nvmeqpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    nvmeqpt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign m_axis_tuser = res.outcome;
    assign m_axis_tdata = {7'd0, res.command_failed, res.completion_status,
                           res.cq_doorbell_value, res.sq_doorbell_value,
                           res.cmd_dword0_out, res.sq_slot};

endmodule

// ===== design/nvmeqpt_checker.sv =====
// port-level checks for the queue pair tracker and their bind
`include "nvme_queue_pair_tracker_defines.svh"

module nvmeqpt_checker
    import nvmeqpt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    `NVMEQPT_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !m_axis_tvalid, "result valid right after reset")

    `NVMEQPT_ASSERT(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // the command identifier in dword 0 is the slot
    `NVMEQPT_ASSERT(a_cid_is_slot, m_axis_tvalid && m_axis_tuser == OUT_SUBMITTED |-> m_axis_tdata[39:24] == {8'd0, m_axis_tdata[7:0]}, "identifier differs from slot")

    `NVMEQPT_ASSERT(a_refused_empty, m_axis_tvalid && (m_axis_tuser == OUT_FULL || m_axis_tuser == OUT_NOT_READY) |-> m_axis_tdata == '0, "refused result carries data")

    `NVMEQPT_ASSERT(a_failed_flag, m_axis_tvalid && m_axis_tuser == OUT_CONSUMED |-> m_axis_tdata[72] == (|m_axis_tdata[64:57]), "error flag does not match status")

endmodule

bind nvme_queue_pair_tracker nvmeqpt_checker u_nvmeqpt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench for the queue pair tracker: directed and random items checked against a local tracker
module testbench;
    import nvmeqpt_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int HOLD_CYCLES     = 300;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_we        = 1'b0;
    logic                  cfg_index     = 1'b0;
    logic [7:0]            cfg_data      = '0;

    // tracked queue pair state and wrap points
    logic [7:0] qp_sq_tail;
    logic [7:0] qp_sq_head;
    logic [7:0] qp_cq_head;
    logic       qp_phase;
    logic [7:0] qp_sq_last;
    logic [7:0] qp_cq_last;

    result_t pending_results[$];
    result_t want_result;
    int      error_count   = 0;
    int      cycle_count   = 0;
    logic    tx_steady     = 1'b0;
    logic    rx_steady     = 1'b0;
    int      hold_requests = 0;
    int      hold_seen     = 0;
    int      hold_left     = 0;

    nvme_queue_pair_tracker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [7:0] ptr_advance(input logic [7:0] ptr, input logic [7:0] last);
        logic [8:0] wrap_at;
        wrap_at = ({1'b0, last} > 9'(MAX_DEPTH - 1)) ? 9'(MAX_DEPTH - 1) : {1'b0, last};
        if ({1'b0, ptr} >= wrap_at)
            return 8'd0;
        return ptr + 8'd1;
    endfunction

    // works out the result of one item and moves the tracked pointers
    function automatic result_t predict_outcome(input logic mode, input logic [31:0] dw0,
                                                input logic [15:0] sts, input logic [7:0] head);
        result_t    r;
        logic [7:0] nxt;
        r = '0;
        if (mode == MODE_SUBMIT)
        begin
            nxt = ptr_advance(qp_sq_tail, qp_sq_last);
            if (nxt == qp_sq_head)
                r.outcome = OUT_FULL;
            else
            begin
                r.outcome           = OUT_SUBMITTED;
                r.sq_slot           = qp_sq_tail;
                r.cmd_dword0_out    = {8'd0, qp_sq_tail, dw0[15:0]};
                r.sq_doorbell_value = nxt;
                qp_sq_tail          = nxt;
            end
        end
        else if (sts[0] != qp_phase)
            r.outcome = OUT_NOT_READY;
        else
        begin
            nxt = ptr_advance(qp_cq_head, qp_cq_last);
            if (nxt < qp_cq_head)
                qp_phase = ~qp_phase;
            qp_cq_head          = nxt;
            qp_sq_head          = head;
            r.outcome           = OUT_CONSUMED;
            r.cq_doorbell_value = nxt;
            r.completion_status = sts;
            r.command_failed    = |sts[8:1];
        end
        return r;
    endfunction

    task automatic send_item(input logic mode, input logic [31:0] dw0, input logic [15:0] sts,
                             input logic [7:0] head);
        if (!tx_steady && $urandom_range(0, 99) < 23)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {head, sts, dw0};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_outcome(mode, dw0, sts, head));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == CFG_SQ_LAST)
            qp_sq_last = value;
        else
            qp_cq_last = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // half submissions, half completions; completions mostly with the expected phase and a plausible head, some noise
    task automatic send_random_item();
        logic [31:0] dw0;
        logic [15:0] sts;
        logic [7:0]  head;
        int          pick;
        dw0  = $urandom;
        sts  = $urandom;
        head = $urandom;
        if ($urandom_range(0, 1) == 0)
            send_item(MODE_SUBMIT, dw0, sts, head);
        else
        begin
            if ($urandom_range(0, 99) < 88)
                sts[0] = qp_phase;
            if ($urandom_range(0, 1) == 0)
                sts[8:1] = 8'd0;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                head = qp_sq_tail;
            else if (pick < 70)
                head = qp_sq_head;
            else if (pick < 90)
                head = $urandom_range(0, qp_sq_last);
            send_item(MODE_COMPLETE, dw0, sts, head);
        end
    endtask

    task automatic run_random_phase(input logic [7:0] sq_last, input logic [7:0] cq_last,
                                    input int count);
        wait_idle();
        write_reg(CFG_SQ_LAST, sq_last);
        write_reg(CFG_CQ_LAST, cq_last);
        repeat (count) send_random_item();
    endtask

    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 23);
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                error_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                check_field("outcome", 32'(want_result.outcome), 32'(m_axis_tuser));
                check_field("sq_slot", 32'(want_result.sq_slot), 32'(m_axis_tdata[7:0]));
                check_field("cmd_dword0_out", want_result.cmd_dword0_out, m_axis_tdata[39:8]);
                check_field("sq_doorbell_value", 32'(want_result.sq_doorbell_value),
                            32'(m_axis_tdata[47:40]));
                check_field("cq_doorbell_value", 32'(want_result.cq_doorbell_value),
                            32'(m_axis_tdata[55:48]));
                check_field("completion_status", 32'(want_result.completion_status),
                            32'(m_axis_tdata[71:56]));
                check_field("command_failed", 32'(want_result.command_failed),
                            32'(m_axis_tdata[72]));
                check_field("tdata fill", 32'd0, 32'(m_axis_tdata[OUT_DATA_W-1:73]));
            end
        end
    end

    // reset wrap points: identifier replacement, phase mismatch and failure bits
    task automatic test_identifier_and_status();
        send_item(MODE_SUBMIT, 32'h0000_0000, 16'h0000, 8'h00);
        send_item(MODE_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_item(MODE_COMPLETE, 32'hFFFF_FFFF, 16'h0000, 8'h00);
        send_item(MODE_COMPLETE, 32'h0000_0000, 16'h0001, 8'h00);
        send_item(MODE_COMPLETE, 32'h0000_0000, 16'h0003, 8'h01);
        send_item(MODE_COMPLETE, 32'h0000_0000, 16'h01FF, 8'h02);
        send_item(MODE_COMPLETE, 32'h0000_0000, 16'hFE01, 8'h02);
        // reported head past the wrap point
        send_item(MODE_COMPLETE, 32'h0000_0000, 16'hFFFF, 8'hFF);
        send_item(MODE_SUBMIT, 32'h1234_5678, 16'h0000, 8'h00);
    endtask

    // two-entry queues: full refusal, tail above the new wrap point, phase toggle
    task automatic test_queue_full();
        wait_idle();
        write_reg(CFG_SQ_LAST, 8'd1);
        write_reg(CFG_CQ_LAST, 8'd1);
        send_item(MODE_SUBMIT, 32'hA5A5_0001, 16'h0000, 8'h00);
        send_item(MODE_SUBMIT, 32'h5A5A_0002, 16'h0000, 8'h00);
        send_item(MODE_COMPLETE, 32'h0, {15'h0000, qp_phase}, 8'h00);
        send_item(MODE_SUBMIT, 32'h0000_0003, 16'h0000, 8'h00);
        send_item(MODE_SUBMIT, 32'h0000_0004, 16'h0000, 8'h00);
        send_item(MODE_COMPLETE, 32'h0, {15'h0040, qp_phase}, qp_sq_tail);
        send_item(MODE_SUBMIT, 32'h0000_0005, 16'h0000, 8'h00);
        send_item(MODE_COMPLETE, 32'h0, {15'h0000, ~qp_phase}, 8'h00);
        send_item(MODE_COMPLETE, 32'h0, {15'h0000, qp_phase}, qp_sq_tail);
        send_item(MODE_COMPLETE, 32'h0, {15'h0000, qp_phase}, qp_sq_tail);
    endtask

    task automatic test_wrap_extremes();
        wait_idle();
        write_reg(CFG_SQ_LAST, 8'd255);
        write_reg(CFG_CQ_LAST, 8'd255);
        send_item(MODE_SUBMIT, 32'hFFFF_0000, 16'h0000, 8'h00);
        send_item(MODE_COMPLETE, 32'h0, {15'h7FFF, qp_phase}, 8'h80);
        wait_idle();
        write_reg(CFG_SQ_LAST, 8'd2);
        send_item(MODE_SUBMIT, 32'h0000_FFFF, 16'h0000, 8'h00);
        send_item(MODE_SUBMIT, 32'h0000_8001, 16'h0000, 8'h00);
    endtask

    task automatic test_random_small_queues();
        run_random_phase(8'd1, 8'd1, ITEMS_PER_PHASE);
    endtask

    task automatic test_random_full_range();
        run_random_phase(8'd255, 8'd255, ITEMS_PER_PHASE);
    endtask

    task automatic test_random_mixed();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random_phase($urandom_range(1, 255), $urandom_range(1, 255), ITEMS_PER_PHASE / 2);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2) send_random_item();
        run_random_phase($urandom_range(2, 16), $urandom_range(2, 16), ITEMS_PER_PHASE);
    endtask

    // receiver stalls long enough for the input side to back up
    task automatic test_receiver_hold();
        wait_idle();
        write_reg(CFG_SQ_LAST, SQ_LAST_RESET);
        write_reg(CFG_CQ_LAST, CQ_LAST_RESET);
        hold_requests++;
        tx_steady = 1'b1;
        repeat (30) send_random_item();
        tx_steady = 1'b0;
        repeat (ITEMS_PER_PHASE - 30) send_random_item();
    endtask

    task automatic test_sender_pause();
        run_random_phase($urandom_range(1, 255), $urandom_range(1, 8), ITEMS_PER_PHASE / 2);
        wait_idle();
        repeat (ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2) send_random_item();
    endtask

    initial
    begin
        qp_sq_tail = 8'd0;
        qp_sq_head = 8'd0;
        qp_cq_head = 8'd0;
        qp_phase   = 1'b1;
        qp_sq_last = SQ_LAST_RESET;
        qp_cq_last = CQ_LAST_RESET;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_identifier_and_status();
        test_queue_full();
        test_wrap_extremes();
        test_random_small_queues();
        test_random_full_range();
        test_random_mixed();
        test_receiver_hold();
        test_sender_pause();

        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
